FILE: rtl/ppdr_pkg.sv
// ----------------------------------------------------------------------------
// ppdr_pkg
// Shared widths, constants, types and helpers of the planar pose integrator.
// ----------------------------------------------------------------------------
package ppdr_pkg;

  localparam int ANGLE_BITS   = 16;
  localparam int POS_BITS     = 32;

  localparam int CORDIC_ITERS = 16;
  localparam int ITER_W       = $clog2(CORDIC_ITERS);
  localparam int CW           = 34;  // CORDIC x/y datapath, Q.30 plus headroom
  localparam int ZW           = 33;  // CORDIC residual angle, 32-bit turn signed
  localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(652032874);

  localparam int MUL_W        = 33;
  localparam int PROD_W       = 2 * MUL_W;
  localparam logic [31:0] INV_TWO_PI_Q32 = 32'd683565276;

  localparam int STEP_RND     = 23;              // Q.39 to Q.16
  localparam int ANG_RND      = 60 - ANGLE_BITS; // Q.60 to binary angle

  localparam logic OP_VEL  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Shared multiplier schedule: one product issued per step, captured a step later
  localparam logic [3:0] MS_VX_C   = 4'd0;
  localparam logic [3:0] MS_VY_S   = 4'd1;
  localparam logic [3:0] MS_VX_S   = 4'd2;
  localparam logic [3:0] MS_VY_C   = 4'd3;
  localparam logic [3:0] MS_RATE_T = 4'd4;
  localparam logic [3:0] MS_A_T    = 4'd5;
  localparam logic [3:0] MS_B_T    = 4'd6;
  localparam logic [3:0] MS_RT_K   = 4'd7;
  localparam logic [3:0] MS_LAST   = 4'd8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COR1,
    ST_MUL,
    ST_HALF,
    ST_COR2,
    ST_OUT
  } seq_state_t;

  typedef struct packed {
    logic        start;
    logic [31:0] turn;
  } cordic_req_t;

  typedef struct packed {
    logic               done;
    logic signed [15:0] sin;
    logic signed [15:0] cos;
  } cordic_res_t;

  function automatic logic [ZW-1:0] atan_turn(input logic [ITER_W-1:0] idx);
    logic [ZW-1:0] v;
    case (idx)
      4'd0:    v = ZW'(536870912);
      4'd1:    v = ZW'(316933406);
      4'd2:    v = ZW'(167458907);
      4'd3:    v = ZW'(85004756);
      4'd4:    v = ZW'(42667331);
      4'd5:    v = ZW'(21354465);
      4'd6:    v = ZW'(10679838);
      4'd7:    v = ZW'(5340245);
      4'd8:    v = ZW'(2670163);
      4'd9:    v = ZW'(1335087);
      4'd10:   v = ZW'(667544);
      4'd11:   v = ZW'(333772);
      4'd12:   v = ZW'(166886);
      4'd13:   v = ZW'(83443);
      4'd14:   v = ZW'(41721);
      4'd15:   v = ZW'(20860);
      default: v = '0;
    endcase
    return v;
  endfunction

  // Round a Q.30 CORDIC value to Q1.15 and clamp
  function automatic logic signed [15:0] round_sat16(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] r;
    r = (v + CW'(16384)) >>> 15;
    if (r > CW'(32767)) return 16'sd32767;
    if (r < -CW'(32768)) return -16'sd32768;
    return r[15:0];
  endfunction

  function automatic logic [31:0] turn_of(input logic [ANGLE_BITS-1:0] ang);
    return 32'(ang) << (32 - ANGLE_BITS);
  endfunction

  function automatic logic [31:0] pos_out(input logic [POS_BITS-1:0] v);
    logic signed [63:0] e;
    e = 64'(signed'(v));
    return e[31:0];
  endfunction

endpackage

FILE: rtl/ppdr_if.sv
// ----------------------------------------------------------------------------
// ppdr_if
// Valid/ready channels of the pose integrator: command/tick in, pose out.
// ----------------------------------------------------------------------------
interface ppdr_in_if import ppdr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               opcode;
  logic signed [15:0] cmd_vx;
  logic signed [15:0] cmd_vy;
  logic signed [15:0] cmd_yaw_rate;
  logic        [15:0] elapsed;

  modport source (output valid, opcode, cmd_vx, cmd_vy, cmd_yaw_rate, elapsed,
                  input ready);
  modport sink   (input valid, opcode, cmd_vx, cmd_vy, cmd_yaw_rate, elapsed,
                  output ready);
endinterface

interface ppdr_out_if import ppdr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic        [15:0] heading;
  logic signed [15:0] quat_z;
  logic signed [15:0] quat_w;
  logic signed [15:0] vel_x;
  logic signed [15:0] vel_y;
  logic signed [15:0] yaw_rate;

  modport source (output valid, pos_x, pos_y, heading, quat_z, quat_w, vel_x, vel_y,
                         yaw_rate,
                  input ready);
  modport sink   (input valid, pos_x, pos_y, heading, quat_z, quat_w, vel_x, vel_y,
                        yaw_rate,
                  output ready);
endinterface

FILE: rtl/planar_pose_dead_reckoning.sv
// ----------------------------------------------------------------------------
// planar_pose_dead_reckoning
// Dead-reckoning pose integrator for a planar robot.
// ----------------------------------------------------------------------------
// Usage:
//   item (sink) takes one beat per command. opcode OP_VEL latches forward
//   speed, lateral speed and yaw rate and produces nothing. opcode OP_TICK
//   carries the elapsed time and produces one beat on pose (source): the
//   wrapped x/y position, the binary heading, the yaw quaternion (z, w of
//   the half heading) and the held velocities.
//   From accept to pose valid a tick runs the CORDIC of the old heading
//   (16 rotations, a rounding step and a hand-over), the eight products
//   through the single shared multiplier, the launch of the second CORDIC,
//   the half-heading CORDIC and the load of the output register. The one
//   CORDIC engine is run twice per tick; item.ready stays low for the whole
//   tick and during reset, so a new tick is not taken before the last one
//   is through. The pose register parts the two sides: once it is loaded
//   the block takes the next beat while pose waits. If the receiver still
//   stalls when the following tick finishes, hold that tick until the
//   register frees up. Synchronous reset clears position, heading and held
//   velocities to zero and drops any pending pose beat.
// ----------------------------------------------------------------------------
module planar_pose_dead_reckoning import ppdr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  ppdr_in_if.sink    item,
  ppdr_out_if.source pose
);

  seq_state_t state;
  seq_state_t state_next;
  logic [3:0] step;

  logic [POS_BITS-1:0]   x_acc;
  logic [POS_BITS-1:0]   y_acc;
  logic [ANGLE_BITS-1:0] angle_acc;
  logic signed [15:0]    held_vx;
  logic signed [15:0]    held_vy;
  logic signed [15:0]    held_rate;
  logic [15:0]           dt;

  logic signed [15:0]    sin_old;
  logic signed [15:0]    cos_old;
  logic signed [31:0]    t0;
  logic signed [32:0]    rot_a;   // vx*c - vy*s
  logic signed [32:0]    rot_b;   // vx*s + vy*c
  logic signed [32:0]    rate_t;  // rate * dt

  logic                  out_valid;
  logic                  load_out;
  logic                  accept;

  cordic_req_t           cor_req;
  cordic_res_t           cor_res;

  logic signed [MUL_W-1:0]  op_a;
  logic signed [MUL_W-1:0]  op_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [31:0]       prod32;
  logic signed [PROD_W-1:0] step_rnd;
  logic signed [PROD_W-1:0] ang_rnd;
  logic signed [MUL_W-1:0]  dt_op;

  ppdr_cordic u_cordic (
    .clk (clk),
    .rst (rst),
    .req (cor_req),
    .res (cor_res)
  );

  ppdr_mul u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  assign accept     = item.valid && item.ready;
  assign item.ready = (state == ST_IDLE) && !rst;
  assign pose.valid = out_valid;
  assign load_out   = (state == ST_OUT) && (!out_valid || pose.ready);

  // Product bookkeeping: position steps round Q.39 to Q.16, heading step
  // rounds Q.60 down to the binary angle.
  always_comb begin
    prod32   = signed'(prod[31:0]);
    step_rnd = (prod + (PROD_W'(1) << (STEP_RND - 1))) >>> STEP_RND;
    ang_rnd  = (prod + (PROD_W'(1) << (ANG_RND - 1))) >>> ANG_RND;
    dt_op    = MUL_W'(signed'({1'b0, dt}));
  end

  // Operand select for the shared multiplier
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (step)
      MS_VX_C:   begin op_a = MUL_W'(held_vx);   op_b = MUL_W'(cos_old); end
      MS_VY_S:   begin op_a = MUL_W'(held_vy);   op_b = MUL_W'(sin_old); end
      MS_VX_S:   begin op_a = MUL_W'(held_vx);   op_b = MUL_W'(sin_old); end
      MS_VY_C:   begin op_a = MUL_W'(held_vy);   op_b = MUL_W'(cos_old); end
      MS_RATE_T: begin op_a = MUL_W'(held_rate); op_b = dt_op; end
      MS_A_T:    begin op_a = MUL_W'(rot_a);     op_b = dt_op; end
      MS_B_T:    begin op_a = MUL_W'(rot_b);     op_b = dt_op; end
      MS_RT_K:   begin op_a = MUL_W'(rate_t);    op_b = MUL_W'(INV_TWO_PI_Q32); end
      default:   begin op_a = '0;                op_b = '0; end
    endcase
  end

  // Sequencer: next state and CORDIC launch
  always_comb begin
    state_next    = state;
    cor_req.start = 1'b0;
    cor_req.turn  = turn_of(angle_acc);
    case (state)
      ST_IDLE: begin
        if (accept && item.opcode == OP_TICK) begin
          cor_req.start = 1'b1;
          state_next    = ST_COR1;
        end
      end
      ST_COR1: begin
        if (cor_res.done) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        if (step == MS_LAST) begin
          state_next = ST_HALF;
        end
      end
      ST_HALF: begin
        // heading already advanced; rotate by half of it for the quaternion
        cor_req.start = 1'b1;
        cor_req.turn  = turn_of(angle_acc) >> 1;
        state_next    = ST_COR2;
      end
      ST_COR2: begin
        if (cor_res.done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= '0;
      out_valid <= 1'b0;
      x_acc     <= '0;
      y_acc     <= '0;
      angle_acc <= '0;
      held_vx   <= '0;
      held_vy   <= '0;
      held_rate <= '0;
    end else begin
      if (accept && item.opcode == OP_VEL) begin
        held_vx   <= item.cmd_vx;
        held_vy   <= item.cmd_vy;
        held_rate <= item.cmd_yaw_rate;
      end
      if (state == ST_MUL) begin
        step <= step + 1'b1;
        // capture the product issued on the previous step
        case (step)
          MS_A_T + 4'd1:  x_acc     <= x_acc + step_rnd[POS_BITS-1:0];
          MS_B_T + 4'd1:  y_acc     <= y_acc + step_rnd[POS_BITS-1:0];
          MS_RT_K + 4'd1: angle_acc <= angle_acc + ang_rnd[ANGLE_BITS-1:0];
          default: ;
        endcase
      end else begin
        step <= '0;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (pose.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath holding registers
  always_ff @(posedge clk) begin
    if (accept && item.opcode == OP_TICK) begin
      dt <= item.elapsed;
    end
    if (state == ST_COR1 && cor_res.done) begin
      sin_old <= cor_res.sin;
      cos_old <= cor_res.cos;
    end
    if (state == ST_MUL) begin
      case (step)
        MS_VX_C + 4'd1:   t0     <= prod32;
        MS_VY_S + 4'd1:   rot_a  <= 33'(t0) - 33'(prod32);
        MS_VX_S + 4'd1:   t0     <= prod32;
        MS_VY_C + 4'd1:   rot_b  <= 33'(t0) + 33'(prod32);
        MS_RATE_T + 4'd1: rate_t <= signed'(prod[32:0]);
        default: ;
      endcase
    end
    if (load_out) begin
      pose.pos_x    <= pos_out(x_acc);
      pose.pos_y    <= pos_out(y_acc);
      pose.heading  <= 16'(turn_of(angle_acc) >> 16);
      pose.quat_z   <= cor_res.sin;
      pose.quat_w   <= cor_res.cos;
      pose.vel_x    <= held_vx;
      pose.vel_y    <= held_vy;
      pose.yaw_rate <= held_rate;
    end
  end

endmodule

FILE: rtl/ppdr_cordic.sv
// ----------------------------------------------------------------------------
// ppdr_cordic
// Iterative CORDIC sine/cosine of a 32-bit turn, one rotation per cycle.
// ----------------------------------------------------------------------------
module ppdr_cordic import ppdr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cordic_req_t req,
  output cordic_res_t res
);

  logic signed [CW-1:0] x;
  logic signed [CW-1:0] y;
  logic signed [ZW-1:0] z;
  logic [ITER_W-1:0]    iter;
  logic                 neg;
  logic                 busy;
  logic                 finish;
  logic                 done;
  logic signed [15:0]   sin_q;
  logic signed [15:0]   cos_q;

  logic [31:0]          folded;
  logic                 fold;
  logic signed [CW-1:0] x_sh;
  logic signed [CW-1:0] y_sh;
  logic signed [ZW-1:0] at;
  logic signed [CW-1:0] x_fin;
  logic signed [CW-1:0] y_fin;

  assign res = {done, sin_q, cos_q};

  always_comb begin
    // fold the left half plane onto the right half, negate at the end
    fold   = req.turn[31] ^ req.turn[30];
    folded = fold ? (req.turn ^ 32'h8000_0000) : req.turn;
    x_sh   = x >>> iter;
    y_sh   = y >>> iter;
    at     = signed'(atan_turn(iter));
    x_fin  = neg ? -x : x;
    y_fin  = neg ? -y : y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      finish <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && iter == ITER_W'(CORDIC_ITERS - 1)) begin
        busy <= 1'b0;
      end
      finish <= busy && iter == ITER_W'(CORDIC_ITERS - 1);
      if (finish) begin
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      x    <= CORDIC_GAIN;
      y    <= '0;
      z    <= ZW'(signed'(folded));
      neg  <= fold;
      iter <= '0;
    end else if (busy) begin
      if (!z[ZW-1]) begin
        x <= x - y_sh;
        y <= y + x_sh;
        z <= z - at;
      end else begin
        x <= x + y_sh;
        y <= y - x_sh;
        z <= z + at;
      end
      iter <= iter + 1'b1;
    end
    if (finish) begin
      cos_q <= round_sat16(x_fin);
      sin_q <= round_sat16(y_fin);
    end
  end

endmodule

FILE: rtl/ppdr_mul.sv
// ----------------------------------------------------------------------------
// ppdr_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module ppdr_mul import ppdr_pkg::*; (
  input  logic                     clk,
  input  logic signed [MUL_W-1:0]  op_a,
  input  logic signed [MUL_W-1:0]  op_b,
  output logic signed [PROD_W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= PROD_W'(op_a) * PROD_W'(op_b);
  end

endmodule
